// ----- rtl/core/rc4_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the RC4 keystream unit.
// No dependencies.
package rc4_pkg;

  localparam int TableSize   = 256;
  localparam int IdxW        = $clog2(TableSize);
  localparam int MaxKeyBytes = 16;
  localparam int KposW       = $clog2(MaxKeyBytes);
  localparam int KeyLenW     = 5;
  localparam int KeyW        = 8 * MaxKeyBytes;
  localparam int ApbAddrW    = 5;
  localparam int ApbDataW    = 64;

  // opcode of a request
  localparam logic OpInit = 1'b0;
  localparam logic OpData = 1'b1;

  // register indexes (paddr[4:3])
  localparam logic [1:0] RegKeyLow  = 2'd0;
  localparam logic [1:0] RegKeyHigh = 2'd1;
  localparam logic [1:0] RegKeyLen  = 2'd2;

  localparam logic [KeyLenW-1:0] KeyLenReset = KeyLenW'(MaxKeyBytes);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_RD_X,
    ST_RD_Y,
    ST_WR_X,
    ST_WR_Y
  } st_e;

  typedef struct packed {
    logic [KeyW-1:0]    key;
    logic [KeyLenW-1:0] key_len;
  } cfg_t;

  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] waddr;
    logic [7:0]      wdata;
    logic [IdxW-1:0] raddr_a;
    logic [IdxW-1:0] raddr_b;
  } perm_req_t;

  typedef struct packed {
    logic       load;
    logic [7:0] out_byte;
    logic       last;
  } res_t;

  // zero counts as one, anything above the maximum saturates
  function automatic logic [KeyLenW-1:0] eff_len(input logic [KeyLenW-1:0] len);
    logic [KeyLenW-1:0] r;
    r = len;
    if (len == '0) r = KeyLenW'(1);
    else if (len > KeyLenW'(MaxKeyBytes)) r = KeyLenW'(MaxKeyBytes);
    return r;
  endfunction

endpackage

// ----- rtl/core/rc4_perm_ram.sv -----
`timescale 1ns / 1ps
// 256x8 permutation memory: one write port, two registered read ports.
// Depends on rc4_pkg.
module rc4_perm_ram (
  input  logic                     clk_i,
  input  rc4_pkg::perm_req_t       req_i,
  output logic [7:0]               rdata_a_o,
  output logic [7:0]               rdata_b_o
);
  import rc4_pkg::*;

  logic [7:0] perm_mem [TableSize];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      perm_mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // read-during-write returns old data
  always_ff @(posedge clk_i) begin
    rdata_a_o <= perm_mem[req_i.raddr_a];
    rdata_b_o <= perm_mem[req_i.raddr_b];
  end

endmodule

// ----- rtl/core/rc4_cfg_regs.sv -----
`timescale 1ns / 1ps
// APB register file: key bytes and key length.
// Depends on rc4_pkg.
module rc4_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rc4_pkg::ApbAddrW-1:0]  paddr,
  input  logic [rc4_pkg::ApbDataW-1:0]  pwdata,
  output logic [rc4_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready,
  output rc4_pkg::cfg_t                 cfg_o
);
  import rc4_pkg::*;

  logic [63:0]        key_low_q, key_high_q;
  logic [KeyLenW-1:0] key_len_q;
  logic               wr_en;
  logic [1:0]         reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
      key_len_q  <= KeyLenReset;
    end else if (wr_en) begin
      case (reg_idx)
        RegKeyLow:  key_low_q  <= pwdata;
        RegKeyHigh: key_high_q <= pwdata;
        RegKeyLen:  key_len_q  <= pwdata[KeyLenW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegKeyLow:  prdata = key_low_q;
      RegKeyHigh: prdata = key_high_q;
      RegKeyLen:  prdata = {{(ApbDataW-KeyLenW){1'b0}}, key_len_q};
      default:    prdata = '0;
    endcase
  end

  assign cfg_o.key     = {key_high_q, key_low_q};
  assign cfg_o.key_len = key_len_q;

endmodule

// ----- rtl/core/rc4_swap_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer: identity fill, key schedule swaps and keystream swaps
// over the permutation memory. Depends on rc4_pkg.
module rc4_swap_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             op_i,
  input  logic [7:0]       data_byte_i,
  input  logic             in_last_i,
  output logic             busy_o,
  input  rc4_pkg::cfg_t    cfg_i,
  output rc4_pkg::perm_req_t mem_o,
  input  logic [7:0]       rdata_a_i,
  input  logic [7:0]       rdata_b_i,
  input  logic             res_ready_i,
  output rc4_pkg::res_t    res_o
);
  import rc4_pkg::*;

  st_e              state_q, state_d;
  logic [IdxW-1:0]  i_q, i_d, j_q, j_d;
  logic             init_q, init_d;
  logic [IdxW-1:0]  x_q, x_d, y_q, y_d;
  logic [7:0]       a_q, a_d, b_q, b_d;
  logic [KposW-1:0] kpos_q, kpos_d;
  logic [7:0]       data_q, data_d;
  logic             last_q, last_d;

  logic             accept;
  logic [7:0]       key_byte;
  logic [KeyLenW-1:0] len;
  logic [IdxW-1:0]  ks_addr;
  logic [7:0]       ks;

  assign busy_o   = (state_q != ST_IDLE);
  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign key_byte = cfg_i.key[{kpos_q, 3'b000} +: 8];
  assign len      = eff_len(cfg_i.key_len);
  assign ks_addr  = a_q + b_q;

  // swap already pending in memory: forward the new values
  always_comb begin
    if (ks_addr == y_q)      ks = a_q;
    else if (ks_addr == x_q) ks = b_q;
    else                     ks = rdata_b_i;
  end

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    init_d  = init_q;
    x_d     = x_q;
    y_d     = y_q;
    a_d     = a_q;
    b_d     = b_q;
    kpos_d  = kpos_q;
    data_d  = data_q;
    last_d  = last_q;
    mem_o   = '0;
    res_o   = '0;
    res_o.out_byte = data_q ^ ks;
    res_o.last     = last_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          data_d = data_byte_i;
          last_d = in_last_i;
          if (op_i == OpInit) begin
            init_d  = 1'b1;
            x_d     = '0;
            state_d = ST_FILL;
          end else begin
            init_d  = 1'b0;
            x_d     = i_q + IdxW'(1);
            i_d     = i_q + IdxW'(1);
            state_d = ST_RD_X;
          end
        end
      end
      ST_FILL: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = x_q;
        mem_o.wdata = x_q;
        x_d         = x_q + IdxW'(1);
        if (x_q == IdxW'(TableSize - 1)) begin
          j_d     = '0;
          kpos_d  = '0;
          state_d = ST_RD_X;
        end
      end
      ST_RD_X: begin
        mem_o.raddr_a = x_q;
        state_d       = ST_RD_Y;
      end
      ST_RD_Y: begin
        a_d = rdata_a_i;
        if (init_q) y_d = j_q + rdata_a_i + key_byte;
        else        y_d = j_q + rdata_a_i;
        j_d           = y_d;
        mem_o.raddr_a = y_d;
        state_d       = ST_WR_X;
      end
      ST_WR_X: begin
        b_d           = rdata_a_i;
        mem_o.we      = 1'b1;
        mem_o.waddr   = x_q;
        mem_o.wdata   = rdata_a_i;
        mem_o.raddr_b = a_q + rdata_a_i;
        state_d       = ST_WR_Y;
      end
      ST_WR_Y: begin
        mem_o.we      = 1'b1;
        mem_o.waddr   = y_q;
        mem_o.wdata   = a_q;
        mem_o.raddr_b = ks_addr;
        if (init_q) begin
          if (x_q == IdxW'(TableSize - 1)) begin
            i_d     = '0;
            j_d     = '0;
            state_d = ST_IDLE;
          end else begin
            x_d = x_q + IdxW'(1);
            if ({1'b0, kpos_q} + KeyLenW'(1) >= len) kpos_d = '0;
            else                                     kpos_d = kpos_q + KposW'(1);
            state_d = ST_RD_X;
          end
        end else if (res_ready_i) begin
          res_o.load = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      init_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      init_q  <= init_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    a_q    <= a_d;
    b_q    <= b_d;
    kpos_q <= kpos_d;
    data_q <= data_d;
    last_q <= last_d;
  end

endmodule

// ----- rtl/core/rc4_keystream_cipher_unit.sv -----
`timescale 1ns / 1ps
// RC4 stream cipher, one byte per request. The permutation sits in a
// single 256x8 RAM with one write and two registered read ports.
// An init request (op_i = 0) holds in_stall_o high while it writes the
// identity and then runs the key-schedule swaps; it produces no output.
// A data request (op_i = 1) holds it high to issue the read of S[i],
// read S[j], then do the two writes of the swap, the keystream read
// riding along on the second read port. The next request is taken in the
// idle cycle after that, so a request is never taken while another is in
// flight; the dependent read-read-write-write walk over one RAM sets that
// limit. Results leave through an output register, so
// a new request is taken while a finished byte still waits downstream; the
// last write cycle of a data request holds while that register is full and
// stalled. Data sent before the first init gives undefined bytes. Registers
// (APB, 64-bit data): 0x00 key bytes 0-7, 0x08 key bytes 8-15, 0x10 length.
// Depends on rc4_pkg and the rc4_* submodules.
module rc4_keystream_cipher_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          op_i,
  input  logic [7:0]                    data_byte_i,
  input  logic                          in_last_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    out_byte_o,
  output logic                          out_last_o,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rc4_pkg::ApbAddrW-1:0]  paddr,
  input  logic [rc4_pkg::ApbDataW-1:0]  pwdata,
  output logic [rc4_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready
);
  import rc4_pkg::*;

  cfg_t       cfg;
  perm_req_t  mem_req;
  res_t       res;
  logic [7:0] rdata_a, rdata_b;
  logic       res_ready;

  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q;
  logic       out_last_q;

  rc4_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rc4_perm_ram u_ram (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  rc4_swap_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .op_i        (op_i),
    .data_byte_i (data_byte_i),
    .in_last_i   (in_last_i),
    .busy_o      (in_stall_o),
    .cfg_i       (cfg),
    .mem_o       (mem_req),
    .rdata_a_i   (rdata_a),
    .rdata_b_i   (rdata_b),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // output slot is free when empty or being drained this cycle
  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res.load)          out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.load) begin
      out_byte_q <= res.out_byte;
      out_last_q <= res.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

`ifndef SYNTHESIS
  // never overwrite a byte still waiting downstream
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.load |-> res_ready)
    else $error("result loaded into occupied output slot");

  // init produces no result in the cycle after it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (op_i == OpInit)) |=> !res.load)
    else $error("result after init request");

  // a data request reaches its swap write-back, where it loads its result or the output register is still full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (op_i == OpData)) |-> ##4 (res.load || out_valid_q))
    else $error("data request did not complete in four cycles");

  // memory writes only while a request is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.we |-> in_stall_o)
    else $error("permutation write while idle");
`endif

endmodule
